// ===== hw/rtl/essvm_pkg.sv =====
// Shared types and constants for the element strain / stress / von Mises block.
// Used by the lane and the top level; depends on nothing.
package essvm_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned ACC_W  = 64;
    localparam int unsigned OPND_W = DATA_W + 1;
    localparam int unsigned PROD_W = 2 * OPND_W;
    localparam int unsigned LANES  = 3;

    // accumulator operations of a lane
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_CLR  = 2'd2;

    // register indexes of the configuration port
    localparam logic [2:0] REG_D_XX = 3'd0;
    localparam logic [2:0] REG_D_XY = 3'd1;
    localparam logic [2:0] REG_D_XS = 3'd2;
    localparam logic [2:0] REG_D_YY = 3'd3;
    localparam logic [2:0] REG_D_YS = 3'd4;
    localparam logic [2:0] REG_D_SS = 3'd5;

    typedef struct packed {
        logic       mul_en;
        logic [1:0] acc_op;
    } lane_ctrl_t;

endpackage

// ===== hw/rtl/essvm_lane.sv =====
// One arithmetic lane: a registered 33x33 signed multiplier feeding a
// saturating 64-bit accumulator. Depends on essvm_pkg.
module essvm_lane (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  essvm_pkg::lane_ctrl_t                    ctrl,
    input  logic signed [essvm_pkg::OPND_W-1:0]      opnd_a,
    input  logic signed [essvm_pkg::OPND_W-1:0]      opnd_b,
    output logic signed [essvm_pkg::PROD_W-1:0]      prod,
    output logic signed [essvm_pkg::ACC_W-1:0]       acc
);

    logic signed [essvm_pkg::PROD_W-1:0] prod_reg;
    logic signed [essvm_pkg::PROD_W-1:0] prod_next;
    logic signed [essvm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [essvm_pkg::ACC_W-1:0]  acc_next;
    logic signed [essvm_pkg::ACC_W:0]    sum_wide;
    logic signed [essvm_pkg::ACC_W-1:0]  sat_sum;

    assign prod_next = opnd_a * opnd_b;

    // signed products of 32-bit values always fit in the accumulator width
    always_comb begin
        sum_wide = {acc_reg[essvm_pkg::ACC_W-1], acc_reg}
                 + {prod_reg[essvm_pkg::ACC_W-1], prod_reg[essvm_pkg::ACC_W-1:0]};
        if (sum_wide[essvm_pkg::ACC_W] != sum_wide[essvm_pkg::ACC_W-1]) begin
            // stick at the limit on overflow
            sat_sum = sum_wide[essvm_pkg::ACC_W] ?
                      {1'b1, {(essvm_pkg::ACC_W-1){1'b0}}} :
                      {1'b0, {(essvm_pkg::ACC_W-1){1'b1}}};
        end else begin
            sat_sum = sum_wide[essvm_pkg::ACC_W-1:0];
        end
    end

    always_comb begin
        case (ctrl.acc_op)
            essvm_pkg::ACC_ADD: acc_next = sat_sum;
            essvm_pkg::ACC_CLR: acc_next = '0;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.mul_en) begin
            prod_reg <= prod_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

    assign prod = prod_reg;
    assign acc  = acc_reg;

endmodule

// ===== hw/rtl/essvm_isqrt.sv =====
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle.
// Standalone; the top level starts it and picks up the root on done.
module essvm_isqrt (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] rad,
    output logic        done,
    output logic [31:0] root
);

    localparam int unsigned STEPS = 32;

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [63:0] probe_reg;
    logic [63:0] trial;
    logic        fits;

    assign trial = res_reg + probe_reg;
    assign fits  = (v_reg >= trial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // pulse done on the last step
            done_reg <= !start && busy_reg && (cnt_reg == 5'(STEPS - 1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            v_reg     <= rad;
            res_reg   <= '0;
            probe_reg <= 64'h4000_0000_0000_0000;
        end else if (busy_reg) begin
            if (fits) begin
                v_reg   <= v_reg - trial;
                res_reg <= (res_reg >> 1) + probe_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            probe_reg <= probe_reg >> 2;
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

// ===== hw/rtl/element_strain_stress_von_mises.sv =====
// Plane-stress strain, stress and von Mises stress of one element, fed one
// strain-displacement column per beat (three matrix entries and a displacement,
// tlast on the final column). Three lanes multiply and accumulate the strain sums
// with saturation; on the last column the same lanes form the three stress rows
// against the symmetric elasticity matrix written over APB, then the squares and
// the cross product of the stresses, and a bit-serial square root gives the
// equivalent stress. Values are signed fixed point with FRAC_BITS fraction bits,
// saturated to 32 bits. Columns are taken only while idle, so each column waits
// until the one before is done; the square-root unit handles one result bit per
// cycle. The result waits in an output register, so columns of the next element
// are taken while it is not yet read.
module element_strain_stress_von_mises #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    // APB configuration port
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    // column input
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // b_normal_x, b_normal_y, b_shear, disp
    input  logic         s_tlast,   // last_col
    // result output
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [223:0] m_tdata    // strain_x, strain_y, shear_strain, stress_x,
                                    // stress_y, shear_stress, von_mises
);

    localparam int unsigned W  = essvm_pkg::DATA_W;
    localparam int unsigned OW = essvm_pkg::OPND_W;
    localparam int unsigned AW = essvm_pkg::ACC_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MUL    = 4'd1;
    localparam logic [3:0] S_ACC    = 4'd2;
    localparam logic [3:0] S_STRAIN = 4'd3;
    localparam logic [3:0] S_SMUL   = 4'd4;
    localparam logic [3:0] S_SACC   = 4'd5;
    localparam logic [3:0] S_STRESS = 4'd6;
    localparam logic [3:0] S_SQ     = 4'd7;
    localparam logic [3:0] S_CROSS  = 4'd8;
    localparam logic [3:0] S_SUM    = 4'd9;
    localparam logic [3:0] S_ROOT   = 4'd10;
    localparam logic [3:0] S_WAIT   = 4'd11;
    localparam logic [3:0] S_OUT    = 4'd12;

    localparam logic signed [AW-1:0] I32_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [AW-1:0] I32_MIN = 64'shFFFF_FFFF_8000_0000;

    // floor(x / 2^FRAC_BITS), saturated to 32 bits signed
    function automatic logic signed [W-1:0] rescale(input logic signed [AW-1:0] x);
        logic signed [AW-1:0] sh;
        sh = x >>> FRAC_BITS;
        if (sh > I32_MAX) begin
            return I32_MAX[W-1:0];
        end else if (sh < I32_MIN) begin
            return I32_MIN[W-1:0];
        end
        return sh[W-1:0];
    endfunction

    function automatic logic signed [OW-1:0] magnitude(input logic signed [W-1:0] v);
        logic signed [OW-1:0] ext;
        ext = {v[W-1], v};
        return v[W-1] ? -ext : ext;
    endfunction

    // configuration
    logic signed [W-1:0] d_xx_reg, d_xy_reg, d_xs_reg, d_yy_reg, d_ys_reg, d_ss_reg;
    logic [2:0]          cfg_idx;
    logic                cfg_wr;

    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_xx_reg <= '0;
            d_xy_reg <= '0;
            d_xs_reg <= '0;
            d_yy_reg <= '0;
            d_ys_reg <= '0;
            d_ss_reg <= '0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                essvm_pkg::REG_D_XX: d_xx_reg <= pwdata;
                essvm_pkg::REG_D_XY: d_xy_reg <= pwdata;
                essvm_pkg::REG_D_XS: d_xs_reg <= pwdata;
                essvm_pkg::REG_D_YY: d_yy_reg <= pwdata;
                essvm_pkg::REG_D_YS: d_ys_reg <= pwdata;
                essvm_pkg::REG_D_SS: d_ss_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            essvm_pkg::REG_D_XX: prdata = d_xx_reg;
            essvm_pkg::REG_D_XY: prdata = d_xy_reg;
            essvm_pkg::REG_D_XS: prdata = d_xs_reg;
            essvm_pkg::REG_D_YY: prdata = d_yy_reg;
            essvm_pkg::REG_D_YS: prdata = d_ys_reg;
            essvm_pkg::REG_D_SS: prdata = d_ss_reg;
            default:             prdata = '0;
        endcase
    end

    logic signed [W-1:0] dmat [essvm_pkg::LANES][essvm_pkg::LANES];

    always_comb begin
        dmat[0][0] = d_xx_reg;
        dmat[0][1] = d_xy_reg;
        dmat[0][2] = d_xs_reg;
        dmat[1][0] = d_xy_reg;
        dmat[1][1] = d_yy_reg;
        dmat[1][2] = d_ys_reg;
        dmat[2][0] = d_xs_reg;
        dmat[2][1] = d_ys_reg;
        dmat[2][2] = d_ss_reg;
    end

    // control and data registers
    logic [3:0]          state_reg, state_next;
    logic [1:0]          cnt_reg;
    logic signed [W-1:0] col_reg [essvm_pkg::LANES];
    logic signed [W-1:0] disp_reg;
    logic                last_reg;
    logic signed [W-1:0] e_reg [essvm_pkg::LANES];
    logic signed [W-1:0] s_reg [essvm_pkg::LANES];
    logic [AW-1:0]       q_reg;
    logic [AW-1:0]       tt_reg;
    logic [AW-1:0]       rad_reg;
    logic                sat_reg;
    logic                m_valid_reg;
    logic [223:0]        m_data_reg;

    // lanes
    essvm_pkg::lane_ctrl_t         lane_ctrl;
    logic signed [OW-1:0]          lane_a [essvm_pkg::LANES];
    logic signed [OW-1:0]          lane_b [essvm_pkg::LANES];
    logic signed [essvm_pkg::PROD_W-1:0] lane_prod [essvm_pkg::LANES];
    logic signed [AW-1:0]          lane_acc [essvm_pkg::LANES];

    for (genvar g = 0; g < essvm_pkg::LANES; g++) begin : g_lane
        essvm_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (lane_ctrl),
            .opnd_a  (lane_a[g]),
            .opnd_b  (lane_b[g]),
            .prod    (lane_prod[g]),
            .acc     (lane_acc[g])
        );
    end

    logic        root_start;
    logic        root_done;
    logic [31:0] root_val;

    essvm_isqrt u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .rad     (rad_reg),
        .done    (root_done),
        .root    (root_val)
    );

    logic out_free;
    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == S_IDLE);
    assign root_start = (state_reg == S_ROOT);

    always_comb begin
        state_next       = state_reg;
        lane_ctrl.mul_en = 1'b0;
        lane_ctrl.acc_op = essvm_pkg::ACC_HOLD;
        for (int i = 0; i < essvm_pkg::LANES; i++) begin
            lane_a[i] = '0;
            lane_b[i] = '0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) state_next = S_MUL;
            end
            S_MUL: begin
                lane_ctrl.mul_en = 1'b1;
                for (int i = 0; i < essvm_pkg::LANES; i++) begin
                    lane_a[i] = {col_reg[i][W-1], col_reg[i]};
                    lane_b[i] = {disp_reg[W-1], disp_reg};
                end
                state_next = S_ACC;
            end
            S_ACC: begin
                lane_ctrl.acc_op = essvm_pkg::ACC_ADD;
                state_next = last_reg ? S_STRAIN : S_IDLE;
            end
            S_STRAIN: begin
                lane_ctrl.acc_op = essvm_pkg::ACC_CLR;
                state_next = S_SMUL;
            end
            S_SMUL: begin
                lane_ctrl.mul_en = 1'b1;
                for (int i = 0; i < essvm_pkg::LANES; i++) begin
                    lane_a[i] = {e_reg[cnt_reg][W-1], e_reg[cnt_reg]};
                    lane_b[i] = {dmat[i][cnt_reg][W-1], dmat[i][cnt_reg]};
                end
                state_next = S_SACC;
            end
            S_SACC: begin
                lane_ctrl.acc_op = essvm_pkg::ACC_ADD;
                state_next = (cnt_reg == 2'd2) ? S_STRESS : S_SMUL;
            end
            S_STRESS: begin
                // sums are free again for the next element
                lane_ctrl.acc_op = essvm_pkg::ACC_CLR;
                state_next = S_SQ;
            end
            S_SQ: begin
                lane_ctrl.mul_en = 1'b1;
                for (int i = 0; i < essvm_pkg::LANES; i++) begin
                    lane_a[i] = magnitude(s_reg[i]);
                    lane_b[i] = magnitude(s_reg[i]);
                end
                state_next = S_CROSS;
            end
            S_CROSS: begin
                lane_ctrl.mul_en = 1'b1;
                lane_a[0] = magnitude(s_reg[0]);
                lane_b[0] = magnitude(s_reg[1]);
                state_next = S_SUM;
            end
            S_SUM:  state_next = S_ROOT;
            S_ROOT: state_next = S_WAIT;
            S_WAIT: begin
                if (root_done) state_next = S_OUT;
            end
            S_OUT: begin
                if (out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    logic [AW:0]   tt_wide;
    logic [AW-1:0] q_mixed;
    logic [AW:0]   total_wide;
    logic [W-1:0]  vm_val;

    assign tt_wide    = {lane_prod[2][AW-1:0], 1'b0} + {1'b0, lane_prod[2][AW-1:0]};
    assign q_mixed    = (s_reg[0][W-1] == s_reg[1][W-1]) ?
                        q_reg - lane_prod[0][AW-1:0] : q_reg + lane_prod[0][AW-1:0];
    assign total_wide = {1'b0, q_mixed} + {1'b0, tt_reg};
    assign vm_val     = sat_reg ? '1 : root_val;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == S_STRAIN) begin
                cnt_reg <= '0;
            end else if (state_reg == S_SACC) begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            if (state_reg == S_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_IDLE && s_tvalid) begin
            col_reg[0] <= s_tdata[31:0];
            col_reg[1] <= s_tdata[63:32];
            col_reg[2] <= s_tdata[95:64];
            disp_reg   <= s_tdata[127:96];
            last_reg   <= s_tlast;
        end
        for (int i = 0; i < essvm_pkg::LANES; i++) begin
            if (state_reg == S_STRAIN) e_reg[i] <= rescale(lane_acc[i]);
            if (state_reg == S_STRESS) s_reg[i] <= rescale(lane_acc[i]);
        end
        if (state_reg == S_CROSS) begin
            q_reg  <= lane_prod[0][AW-1:0] + lane_prod[1][AW-1:0];
            tt_reg <= tt_wide[AW-1:0];
        end
        if (state_reg == S_SUM) begin
            rad_reg <= total_wide[AW-1:0];
            sat_reg <= total_wide[AW];
        end
        if (state_reg == S_OUT && out_free) begin
            m_data_reg <= {vm_val, s_reg[2], s_reg[1], s_reg[0],
                           e_reg[2], e_reg[1], e_reg[0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
